// File: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define PSD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("psd assertion failed");

// condition implies a property in the same cycle
`define PSD_ASSERT_IMP(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("psd implication failed");

`endif

// File: rtl/core/psd_pkg.sv
package psd_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int MAG_W      = COORD_BITS;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DOT_W      = PROD_W + 1;
    localparam int NORM_W     = 2 * COORD_BITS + 1;
    localparam int U_BITS     = COORD_BITS + 2;
    localparam int UPROD_W    = U_BITS + 1 + MAG_W;
    localparam int DX_W       = COORD_BITS + 2;
    localparam int SUM_W      = 2 * COORD_BITS + 1;
    localparam int ROOT_W     = COORD_BITS + 1;
    localparam int OUT_W      = COORD_BITS + 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] qx;
        logic signed [COORD_BITS-1:0] qy;
        logic signed [DIFF_W-1:0]     px;
        logic signed [DIFF_W-1:0]     py;
    } t_geo;

    typedef enum logic [1:0] {
        U_ZERO,
        U_ONE,
        U_DIV
    } t_umode;

endpackage

// File: rtl/core/psd_front.sv
module psd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [psd_pkg::COORD_BITS-1:0] i_ax,
    input  logic signed [psd_pkg::COORD_BITS-1:0] i_ay,
    input  logic signed [psd_pkg::COORD_BITS-1:0] i_bx,
    input  logic signed [psd_pkg::COORD_BITS-1:0] i_by,
    input  logic signed [psd_pkg::COORD_BITS-1:0] i_qx,
    input  logic signed [psd_pkg::COORD_BITS-1:0] i_qy,
    output logic                                o_valid,
    output logic signed [psd_pkg::DOT_W-1:0]    o_dot,
    output logic [psd_pkg::NORM_W-1:0]          o_norm,
    output psd_pkg::t_geo                       o_geo
);
    import psd_pkg::*;

    logic                     r_v1, r_v2, r_v3;
    t_geo                     r_geo1, r_geo2, r_geo3;
    logic signed [DIFF_W-1:0] r_ex, r_ey;
    logic signed [PROD_W-1:0] r_nx, r_ny, r_tx, r_ty;
    logic signed [DOT_W-1:0]  r_dot;
    logic [NORM_W-1:0]        r_norm;
    t_geo                     n_geo1;
    logic signed [DOT_W-1:0]  n_norm_w;

    always_comb begin
        n_geo1.ax = i_ax;
        n_geo1.ay = i_ay;
        n_geo1.qx = i_qx;
        n_geo1.qy = i_qy;
        n_geo1.px = DIFF_W'(i_bx) - DIFF_W'(i_ax);
        n_geo1.py = DIFF_W'(i_by) - DIFF_W'(i_ay);
        n_norm_w  = DOT_W'(r_nx) + DOT_W'(r_ny);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // differences
            r_geo1 <= n_geo1;
            r_ex   <= DIFF_W'(i_qx) - DIFF_W'(i_ax);
            r_ey   <= DIFF_W'(i_qy) - DIFF_W'(i_ay);
            // products
            r_geo2 <= r_geo1;
            r_nx   <= r_geo1.px * r_geo1.px;
            r_ny   <= r_geo1.py * r_geo1.py;
            r_tx   <= r_ex * r_geo1.px;
            r_ty   <= r_ey * r_geo1.py;
            // sums
            r_geo3 <= r_geo2;
            r_dot  <= DOT_W'(r_tx) + DOT_W'(r_ty);
            r_norm <= n_norm_w[NORM_W-1:0];
        end
    end

    assign o_valid = r_v3;
    assign o_dot   = r_dot;
    assign o_norm  = r_norm;
    assign o_geo   = r_geo3;

endmodule

// File: rtl/core/psd_div.sv
`include "assert_macros.svh"

module psd_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic signed [psd_pkg::DOT_W-1:0] i_dot,
    input  logic [psd_pkg::NORM_W-1:0]       i_norm,
    input  psd_pkg::t_geo                    i_geo,
    output logic                             o_valid,
    output logic [psd_pkg::U_BITS:0]         o_u,
    output psd_pkg::t_geo                    o_geo
);
    import psd_pkg::*;

    localparam int NS = U_BITS + 1;

    logic              r_v    [NS];
    t_umode            r_mode [NS];
    logic [NORM_W-1:0] r_rem  [NS];
    logic [NORM_W-1:0] r_norm [NS];
    logic [U_BITS-1:0] r_q    [NS];
    t_geo              r_geo  [NS];

    logic              n_v    [NS];
    t_umode            n_mode [NS];
    logic [NORM_W-1:0] n_rem  [NS];
    logic [NORM_W-1:0] n_norm [NS];
    logic [U_BITS-1:0] n_q    [NS];
    t_geo              n_geo  [NS];

    always_comb begin
        logic [NORM_W:0] sh;
        logic [NORM_W:0] dif;
        // classify the projection parameter
        n_v[0]    = i_valid;
        n_norm[0] = i_norm;
        n_geo[0]  = i_geo;
        n_q[0]    = '0;
        n_rem[0]  = i_dot[NORM_W-1:0];
        if (i_norm == '0 || i_dot <= 0) begin
            n_mode[0] = U_ZERO;
        end else if (i_dot >= $signed({{(DOT_W-NORM_W){1'b0}}, i_norm})) begin
            n_mode[0] = U_ONE;
        end else begin
            n_mode[0] = U_DIV;
        end
        // one quotient bit per stage
        for (int k = 1; k < NS; k++) begin
            sh        = {r_rem[k-1], 1'b0};
            dif       = sh - {1'b0, r_norm[k-1]};
            n_v[k]    = r_v[k-1];
            n_mode[k] = r_mode[k-1];
            n_norm[k] = r_norm[k-1];
            n_geo[k]  = r_geo[k-1];
            if (!dif[NORM_W]) begin
                n_rem[k] = dif[NORM_W-1:0];
                n_q[k]   = {r_q[k-1][U_BITS-2:0], 1'b1};
            end else begin
                n_rem[k] = sh[NORM_W-1:0];
                n_q[k]   = {r_q[k-1][U_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_v[k] <= n_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_mode[k] <= n_mode[k];
                r_rem[k]  <= n_rem[k];
                r_norm[k] <= n_norm[k];
                r_q[k]    <= n_q[k];
                r_geo[k]  <= n_geo[k];
            end
        end
    end

    always_comb begin
        case (r_mode[NS-1])
            U_ONE:   o_u = {1'b1, {U_BITS{1'b0}}};
            U_DIV:   o_u = {1'b0, r_q[NS-1]};
            default: o_u = '0;
        endcase
    end

    assign o_valid = r_v[NS-1];
    assign o_geo   = r_geo[NS-1];

    `PSD_ASSERT_IMP(a_rem_below_norm, i_clk, i_rst_n, r_v[NS-1] && r_mode[NS-1] == U_DIV, r_rem[NS-1] < r_norm[NS-1])

endmodule

// File: rtl/core/psd_near.sv
module psd_near (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [psd_pkg::U_BITS:0]   i_u,
    input  psd_pkg::t_geo              i_geo,
    output logic                       o_valid,
    output logic [psd_pkg::SUM_W-1:0]  o_sum
);
    import psd_pkg::*;

    logic                      r_va, r_vb, r_vc, r_vd;
    t_geo                      r_geo;
    logic [UPROD_W-1:0]        r_mx, r_my;
    logic signed [DX_W-1:0]    r_dx, r_dy;
    logic [SUM_W-1:0]          r_sx, r_sy, r_sum;
    logic [DIFF_W-1:0]         n_apx, n_apy;
    logic [UPROD_W:0]          n_rx, n_ry;
    logic signed [DX_W-1:0]    n_ox, n_oy, n_nx, n_ny;
    logic signed [2*DX_W-1:0]  n_sqx, n_sqy;

    always_comb begin
        n_apx = i_geo.px[DIFF_W-1] ? -i_geo.px : i_geo.px;
        n_apy = i_geo.py[DIFF_W-1] ? -i_geo.py : i_geo.py;
        // round half up on the offset magnitude
        n_rx  = (UPROD_W+1)'(r_mx) + ((UPROD_W+1)'(1) << (U_BITS - 1));
        n_ry  = (UPROD_W+1)'(r_my) + ((UPROD_W+1)'(1) << (U_BITS - 1));
        n_ox  = $signed({1'b0, n_rx[U_BITS+DX_W-2:U_BITS]});
        n_oy  = $signed({1'b0, n_ry[U_BITS+DX_W-2:U_BITS]});
        n_nx  = r_geo.px[DIFF_W-1] ? DX_W'(r_geo.ax) - n_ox : DX_W'(r_geo.ax) + n_ox;
        n_ny  = r_geo.py[DIFF_W-1] ? DX_W'(r_geo.ay) - n_oy : DX_W'(r_geo.ay) + n_oy;
        n_sqx = r_dx * r_dx;
        n_sqy = r_dy * r_dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_geo <= i_geo;
            r_mx  <= UPROD_W'(i_u) * UPROD_W'(n_apx[MAG_W-1:0]);
            r_my  <= UPROD_W'(i_u) * UPROD_W'(n_apy[MAG_W-1:0]);
            r_dx  <= n_nx - DX_W'(r_geo.qx);
            r_dy  <= n_ny - DX_W'(r_geo.qy);
            r_sx  <= n_sqx[SUM_W-1:0];
            r_sy  <= n_sqy[SUM_W-1:0];
            r_sum <= r_sx + r_sy;
        end
    end

    assign o_valid = r_vd;
    assign o_sum   = r_sum;

endmodule

// File: rtl/core/psd_sqrt.sv
`include "assert_macros.svh"

module psd_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [psd_pkg::SUM_W-1:0]  i_sum,
    output logic                       o_valid,
    output logic [psd_pkg::OUT_W-1:0]  o_dist
);
    import psd_pkg::*;

    localparam int NS  = ROOT_W + 1;
    localparam int T_W = SUM_W + 2;

    logic              r_v    [NS];
    logic [SUM_W-1:0]  r_rem  [NS];
    logic [ROOT_W-1:0] r_root [NS];
    logic              n_v    [NS];
    logic [SUM_W-1:0]  n_rem  [NS];
    logic [ROOT_W-1:0] n_root [NS];
    logic              r_ov;
    logic [OUT_W-1:0]  r_dist;
    logic [OUT_W:0]    n_inc;
    logic [OUT_W-1:0]  n_dist;

    always_comb begin
        logic [T_W-1:0] trial;
        logic [T_W-1:0] dif;
        n_v[0]    = i_valid;
        n_rem[0]  = i_sum;
        n_root[0] = '0;
        // one root bit per stage, most significant first
        for (int k = 1; k < NS; k++) begin
            trial = (T_W'(r_root[k-1]) << (ROOT_W - k + 1))
                  + (T_W'(1) << (2 * (ROOT_W - k)));
            dif   = T_W'(r_rem[k-1]) - trial;
            n_v[k] = r_v[k-1];
            if (!dif[T_W-1]) begin
                n_rem[k]  = dif[SUM_W-1:0];
                n_root[k] = r_root[k-1] | (ROOT_W'(1) << (ROOT_W - k));
            end else begin
                n_rem[k]  = r_rem[k-1];
                n_root[k] = r_root[k-1];
            end
        end
        // round to nearest, then saturate
        n_inc = (OUT_W+1)'(r_root[NS-1])
              + ((SUM_W'(r_rem[NS-1]) > SUM_W'(r_root[NS-1])) ? (OUT_W+1)'(1) : '0);
        n_dist = n_inc[OUT_W] ? {OUT_W{1'b1}} : n_inc[OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_v[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_v[k] <= n_v[k];
            end
            r_ov <= r_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
            r_dist <= n_dist;
        end
    end

    assign o_valid = r_ov;
    assign o_dist  = r_dist;

    `PSD_ASSERT_IMP(a_root_rem_bound, i_clk, i_rst_n, r_v[NS-1], r_rem[NS-1] <= SUM_W'({r_root[NS-1], 1'b0}))
    `PSD_ASSERT_IMP(a_dist_in_range, i_clk, i_rst_n, r_ov, !r_dist[OUT_W-1])

endmodule

// File: rtl/core/point_segment_distance.sv
// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------
// query in  | i_valid / o_ready  | i_seg_start_x/y, i_seg_end_x/y, i_query_x/y
// result out| o_valid / i_ready  | o_distance
//
// one transaction enters per cycle while o_ready is high; each result reaches o_valid
// through 61 registers: 3 front, 27 divider, 4 nearest-point, 27 square root
// synchronous active-low reset clears only the valid bits of every stage
// a stall at the output freezes the whole pipeline, so nothing is lost or
// repeated; o_ready falls only while a result waits and i_ready is low
module point_segment_distance (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [psd_pkg::COORD_BITS-1:0] i_seg_start_x,
    input  logic signed [psd_pkg::COORD_BITS-1:0] i_seg_start_y,
    input  logic signed [psd_pkg::COORD_BITS-1:0] i_seg_end_x,
    input  logic signed [psd_pkg::COORD_BITS-1:0] i_seg_end_y,
    input  logic signed [psd_pkg::COORD_BITS-1:0] i_query_x,
    input  logic signed [psd_pkg::COORD_BITS-1:0] i_query_y,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [psd_pkg::OUT_W-1:0]             o_distance
);
    import psd_pkg::*;

    // global advance: the pipeline moves unless a result is held back
    logic              en;
    logic              f_valid;
    logic signed [DOT_W-1:0] f_dot;
    logic [NORM_W-1:0] f_norm;
    t_geo              f_geo;
    logic              d_valid;
    logic [U_BITS:0]   d_u;
    t_geo              d_geo;
    logic              n_valid;
    logic [SUM_W-1:0]  n_sum;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // differences, products, dot product and squared length
    psd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_ax    (i_seg_start_x),
        .i_ay    (i_seg_start_y),
        .i_bx    (i_seg_end_x),
        .i_by    (i_seg_end_y),
        .i_qx    (i_query_x),
        .i_qy    (i_query_y),
        .o_valid (f_valid),
        .o_dot   (f_dot),
        .o_norm  (f_norm),
        .o_geo   (f_geo)
    );

    // clamped projection parameter, coincident endpoints give zero
    psd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_dot   (f_dot),
        .i_norm  (f_norm),
        .i_geo   (f_geo),
        .o_valid (d_valid),
        .o_u     (d_u),
        .o_geo   (d_geo)
    );

    // nearest point and squared distance to it
    psd_near u_near (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_u     (d_u),
        .i_geo   (d_geo),
        .o_valid (n_valid),
        .o_sum   (n_sum)
    );

    // rounded square root into the output register
    psd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (n_valid),
        .i_sum   (n_sum),
        .o_valid (o_valid),
        .o_dist  (o_distance)
    );

endmodule
